>>> sv/assert_macros.svh
// Assertion helpers shared by the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// Implication checked on every rising clock edge outside reset.
`define ASSERT_IMPLY(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);
// Next-cycle implication checked outside reset.
`define ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);
`endif

>>> sv/goe_pkg.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// goe_pkg
// Shared types and constants of the genetic optimizer engine.
// ---------------------------------------------------------------------------
package goe_pkg;
   localparam int POP_SIZE_DEF    = 20;
   localparam int ELITE_COUNT_DEF = 2;
   localparam int MAX_GENES_DEF   = 16;
   localparam int GENE_BITS_DEF   = 32;
   localparam logic [31:0] LFSR_MASK = 32'hD000_0001;
   localparam logic signed [31:0] SCORE_MIN = 32'sh8000_0000;

   typedef enum logic [2:0] {
      REQ_BOUND = 3'd0, REQ_RAND = 3'd1, REQ_READ = 3'd2,
      REQ_SCORE = 3'd3, REQ_EVOLVE = 3'd4
   } req_code_type;

   typedef enum logic [1:0] {
      CSR_GENES = 2'd0, CSR_SEED = 2'd1, CSR_XOVER = 2'd2, CSR_MUT = 2'd3
   } csr_code_type;

   typedef enum logic [4:0] {
      ST_IDLE, ST_DECODE, ST_READ, ST_READ_WAIT, ST_RAND_GENE, ST_RAND_MUL,
      ST_RAND_WR, ST_SORT_INIT, ST_SORT_CMP, ST_SORT_STEP, ST_ELITE_RD,
      ST_ELITE_WR, ST_TOUR_DRAW, ST_TOUR_CMP, ST_XO_DRAW, ST_CUT_DRAW,
      ST_GENE_RD, ST_GENE_WAIT, ST_MUT_DRAW, ST_MUT_VAL, ST_MUT_MUL,
      ST_GENE_WR, ST_COPY_RD, ST_COPY_WR, ST_DONE, ST_RESP
   } state_type;

   // One LFSR step, upper half is the 16-bit draw.
   function automatic logic [31:0] lfsr_next(input logic [31:0] w);
      logic [31:0] s;
      s = {1'b0, w[31:1]};
      if (w[0]) s = s ^ LFSR_MASK;
      return s;
   endfunction
endpackage

>>> sv/genetic_optimizer_engine.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// genetic_optimizer_engine
// Genetic optimizer: population store, tournament selection, crossover and
// mutation around one shared multiplier under a sequencer.
// ---------------------------------------------------------------------------
// One request at a time. Bound writes and score sets are settled in the
// decode state; a gene read goes through the memory and its registered
// read data. Randomize draws and scales one value per gene in use for each
// individual and writes zero to the unused genes. Evolve runs an insertion
// sort of the population by score and copies the elites. It then builds
// each child from two tournaments, a crossover draw and, on a hit, a cut
// draw, a pass in which each gene in use may mutate, and a copy of the
// unused genes from parent one. The single-port gene memory and the shared
// multiplier set the pace. The result is held in an output register until
// taken.
`include "assert_macros.svh"
module genetic_optimizer_engine
   import goe_pkg::*;
#(
   parameter int POP_SIZE    = POP_SIZE_DEF,
   parameter int ELITE_COUNT = ELITE_COUNT_DEF,
   parameter int MAX_GENES   = MAX_GENES_DEF
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   // tdata: req_type[2:0], individual_index[8:3], gene_index[12:9],
   // bound_low[44:13], bound_high[76:45], score_value[108:77]
   input  logic [111:0] req_tdata,
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   // tdata: status[0], gene_value[32:1], generation[64:33], best_score[96:65]
   output logic [103:0] rsp_tdata,
   input  logic         csr_valid,
   output logic         csr_ready,
   input  logic [1:0]   csr_index,
   input  logic [31:0]  csr_data
);
   localparam int PW = $clog2(POP_SIZE);
   localparam int GW = (MAX_GENES > 1) ? $clog2(MAX_GENES) : 1;
   localparam int CW = $clog2(MAX_GENES + 1);
   localparam int DEPTH = POP_SIZE * MAX_GENES;
   localparam int AW = $clog2(DEPTH);
   localparam int ELITES = (ELITE_COUNT > POP_SIZE) ? POP_SIZE : ELITE_COUNT;
   localparam int SW = $clog2(2 * POP_SIZE + 1);

   state_type state_ff, state_in;
   logic [4:0]  genes_cfg_ff;
   logic [31:0] seed_ff;
   logic [15:0] xo_thr_ff, mut_thr_ff;

   logic [2:0]  rq_type_ff;
   logic [5:0]  rq_ind_ff;
   logic [3:0]  rq_gene_ff;
   logic [31:0] rq_low_ff, rq_high_ff, rq_score_ff;

   logic signed [31:0] score_ff [POP_SIZE];
   logic signed [31:0] nscore_ff [POP_SIZE];
   logic signed [31:0] low_ff [MAX_GENES];
   logic signed [31:0] high_ff [MAX_GENES];
   logic [PW-1:0] order_ff [POP_SIZE];
   logic [31:0]  lfsr_ff, gen_ff;

   logic [PW:0]  i_ff;      // outer index (individual, child, sort i)
   logic [PW:0]  j_ff;      // sort inner index
   logic [PW-1:0] cur_ff;
   logic [CW:0]  g_ff;      // gene counter
   logic [CW-1:0] cut_ff;
   logic         xo_ff, second_ff;
   logic [PW-1:0] ta_ff, p1_ff, p2_ff;
   logic [31:0]  gene_ff;
   logic signed [31:0] best_ff;
   logic         status_ff;
   logic [31:0]  rgene_ff;
   logic         rsp_valid_ff;
   logic [103:0] rsp_data_ff;
   logic         buf_sel_ff;   // which half of the memory is current

   logic [CW-1:0] n_eff;
   always_comb begin
      if (genes_cfg_ff == 5'd0) n_eff = CW'(1);
      else if (32'(genes_cfg_ff) > MAX_GENES) n_eff = CW'(MAX_GENES);
      else n_eff = CW'(genes_cfg_ff);
   end

   logic read_ok, req_bad;
   assign read_ok = 32'(rq_ind_ff) < POP_SIZE && {1'b0, rq_gene_ff} < 5'(n_eff);
   always_comb begin
      case (rq_type_ff)
         REQ_BOUND:            req_bad = !(32'(rq_gene_ff) < MAX_GENES);
         REQ_READ:             req_bad = !read_ok;
         REQ_SCORE:            req_bad = !(32'(rq_ind_ff) < POP_SIZE);
         REQ_RAND, REQ_EVOLVE: req_bad = 1'b0;
         default:              req_bad = 1'b1;
      endcase
   end

   // Memory holds two banks; buf_sel_ff selects the live population.
   logic         ram_we;
   logic [AW:0]  ram_addr;
   logic [31:0]  ram_wdata, ram_rdata;
   goe_gene_ram #(.DEPTH(2 * DEPTH), .WIDTH(32)) u_ram (
      .clock(clock), .wr_en(ram_we), .addr(ram_addr),
      .wr_data(ram_wdata), .rd_data(ram_rdata));

   logic [15:0] m_draw;
   logic signed [32:0] m_span;
   logic [31:0] m_base, m_res;
   goe_mul u_mul (.clock(clock), .draw(m_draw), .span(m_span), .base(m_base),
      .result(m_res));

   logic [31:0] lfsr_nx;
   logic [15:0] draw;
   assign lfsr_nx = lfsr_next(lfsr_ff);
   assign draw    = lfsr_nx[31:16];

   logic [GW-1:0] gidx;
   assign gidx = g_ff[GW-1:0];
   always_comb begin
      m_draw = draw;
      m_span = 33'($signed(high_ff[gidx])) - 33'($signed(low_ff[gidx]));
      m_base = low_ff[gidx];
   end

   logic [PW-1:0] pick;
   logic [PW+15:0] pick_prod;
   assign pick_prod = draw * (PW + 16)'(POP_SIZE);
   assign pick = pick_prod[PW+15:16];
   logic [CW+15:0] cut_prod;
   assign cut_prod = draw * (CW + 16)'(n_eff - CW'(1));

   function automatic logic [AW:0] addr_of(input logic bank, input logic [PW-1:0] ind,
                                           input logic [GW-1:0] g);
      logic [AW:0] a;
      a = (AW + 1)'(ind) * (AW + 1)'(MAX_GENES) + (AW + 1)'(g);
      if (bank) a = a + (AW + 1)'(DEPTH);
      return a;
   endfunction

   logic req_acc, rsp_acc;
   assign req_tready = (state_ff == ST_IDLE);
   assign req_acc    = req_tvalid && req_tready;
   assign rsp_acc    = rsp_valid_ff && rsp_tready;
   assign csr_ready  = (state_ff == ST_IDLE);
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   logic [PW-1:0] i_p, j_p, jm1_p;
   assign i_p = i_ff[PW-1:0];
   assign j_p = j_ff[PW-1:0];
   assign jm1_p = PW'(j_ff - (PW + 1)'(1));
   logic sort_move;
   assign sort_move = (j_ff != '0) && (score_ff[order_ff[jm1_p]] < score_ff[cur_ff]);
   logic live;
   assign live = buf_sel_ff;

   // Next-state logic.
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE:      if (req_acc) state_in = ST_DECODE;
         ST_DECODE: begin
            case (rq_type_ff)
               REQ_RAND:   state_in = ST_RAND_GENE;
               REQ_READ:   state_in = read_ok ? ST_READ : ST_RESP;
               REQ_EVOLVE: state_in = ST_SORT_INIT;
               default:    state_in = ST_RESP;
            endcase
         end
         ST_READ:      state_in = ST_READ_WAIT;
         ST_READ_WAIT: state_in = ST_RESP;
         ST_RAND_GENE: begin
            if (i_ff == (PW + 1)'(POP_SIZE)) state_in = ST_RESP;
            else if (g_ff < (CW + 1)'(n_eff)) state_in = ST_RAND_MUL;
            else state_in = ST_RAND_WR;
         end
         ST_RAND_MUL:  state_in = ST_RAND_WR;
         ST_RAND_WR:   state_in = ST_RAND_GENE;
         ST_SORT_INIT: state_in = (i_ff == (PW + 1)'(POP_SIZE)) ? ST_ELITE_RD : ST_SORT_CMP;
         ST_SORT_CMP:  state_in = sort_move ? ST_SORT_CMP : ST_SORT_STEP;
         ST_SORT_STEP: state_in = ST_SORT_INIT;
         ST_ELITE_RD: begin
            if (i_ff >= (PW + 1)'(ELITES)) state_in = ST_TOUR_DRAW;
            else if (g_ff == (CW + 1)'(MAX_GENES)) state_in = ST_ELITE_RD;
            else state_in = ST_ELITE_WR;
         end
         ST_ELITE_WR:  state_in = ST_ELITE_RD;
         ST_TOUR_DRAW: state_in = (i_ff == (PW + 1)'(POP_SIZE)) ? ST_DONE : ST_TOUR_CMP;
         ST_TOUR_CMP:  state_in = second_ff ? ST_XO_DRAW : ST_TOUR_DRAW;
         ST_XO_DRAW:   state_in = (n_eff > CW'(1) && draw < xo_thr_ff) ? ST_CUT_DRAW
                                                                       : ST_GENE_RD;
         ST_CUT_DRAW:  state_in = ST_GENE_RD;
         ST_GENE_RD:   state_in = (g_ff == (CW + 1)'(n_eff)) ? ST_COPY_RD : ST_GENE_WAIT;
         ST_GENE_WAIT: state_in = ST_MUT_DRAW;
         ST_MUT_DRAW:  state_in = (draw < mut_thr_ff) ? ST_MUT_VAL : ST_GENE_WR;
         ST_MUT_VAL:   state_in = ST_MUT_MUL;
         ST_MUT_MUL:   state_in = ST_GENE_WR;
         ST_GENE_WR:   state_in = ST_GENE_RD;
         ST_COPY_RD:   state_in = (g_ff == (CW + 1)'(MAX_GENES)) ? ST_TOUR_DRAW : ST_COPY_WR;
         ST_COPY_WR:   state_in = ST_COPY_RD;
         ST_DONE:      state_in = ST_RESP;
         ST_RESP:      if (!rsp_valid_ff || rsp_acc) state_in = ST_IDLE;
         default:      state_in = ST_IDLE;
      endcase
   end

   // Memory port control. Genes from the crossover cut upward come from the second
   // parent only while they are in use; the rest always follow parent one.
   logic [PW-1:0] gsrc;
   assign gsrc = (xo_ff && g_ff >= (CW + 1)'(cut_ff) && g_ff < (CW + 1)'(n_eff))
                 ? p2_ff : p1_ff;
   always_comb begin
      ram_we    = 1'b0;
      ram_addr  = '0;
      ram_wdata = m_res;
      case (state_ff)
         ST_READ:     ram_addr = addr_of(live, rq_ind_ff[PW-1:0], rq_gene_ff[GW-1:0]);
         ST_RAND_WR: begin
            ram_we = 1'b1;
            ram_addr = addr_of(live, i_p, gidx);
            ram_wdata = (g_ff < (CW + 1)'(n_eff)) ? gene_ff : 32'd0;
         end
         ST_ELITE_RD: ram_addr = addr_of(live, order_ff[i_p], gidx);
         ST_ELITE_WR: begin
            ram_we = 1'b1;
            ram_addr = addr_of(!live, i_p, gidx);
            ram_wdata = ram_rdata;
         end
         ST_GENE_RD, ST_GENE_WAIT, ST_COPY_RD: ram_addr = addr_of(live, gsrc, gidx);
         ST_GENE_WR: begin
            ram_we = 1'b1;
            ram_addr = addr_of(!live, i_p, gidx);
            ram_wdata = gene_ff;
         end
         ST_COPY_WR: begin
            ram_we = 1'b1;
            ram_addr = addr_of(!live, i_p, gidx);
            ram_wdata = ram_rdata;
         end
         default: ram_addr = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         genes_cfg_ff <= 5'd4;
         seed_ff <= 32'd1;
         xo_thr_ff <= 16'd45875;
         mut_thr_ff <= 16'd6554;
         lfsr_ff <= 32'd1;
         gen_ff <= '0;
         rsp_valid_ff <= 1'b0;
         buf_sel_ff <= 1'b0;
         for (int k = 0; k < POP_SIZE; k++) begin
            score_ff[k] <= SCORE_MIN;
            order_ff[k] <= PW'(k);
         end
         for (int k = 0; k < MAX_GENES; k++) begin
            low_ff[k] <= '0;
            high_ff[k] <= '0;
         end
      end else begin
         state_ff <= state_in;
         if (state_ff == ST_RESP && (!rsp_valid_ff || rsp_acc)) rsp_valid_ff <= 1'b1;
         else if (rsp_acc) rsp_valid_ff <= 1'b0;
         if (csr_valid && csr_ready) begin
            case (csr_index)
               CSR_GENES: genes_cfg_ff <= csr_data[4:0];
               CSR_SEED:  seed_ff <= csr_data;
               CSR_XOVER: xo_thr_ff <= csr_data[15:0];
               CSR_MUT:   mut_thr_ff <= csr_data[15:0];
               default:   ;
            endcase
         end
         case (state_ff)
            ST_IDLE: if (req_acc) begin
               rq_type_ff <= req_tdata[2:0];
               rq_ind_ff <= req_tdata[8:3];
               rq_gene_ff <= req_tdata[12:9];
               rq_low_ff <= req_tdata[44:13];
               rq_high_ff <= req_tdata[76:45];
               rq_score_ff <= req_tdata[108:77];
            end
            ST_DECODE: begin
               status_ff <= req_bad;
               rgene_ff <= '0;
               best_ff <= '0;
               i_ff <= (rq_type_ff == REQ_EVOLVE) ? (PW + 1)'(1) : '0;
               g_ff <= '0;
               case (rq_type_ff)
                  REQ_BOUND: if (!req_bad) begin
                     low_ff[rq_gene_ff[GW-1:0]] <= rq_low_ff;
                     high_ff[rq_gene_ff[GW-1:0]] <= rq_high_ff;
                  end
                  REQ_RAND: begin
                     lfsr_ff <= (seed_ff != '0) ? seed_ff : 32'd1;
                     for (int k = 0; k < POP_SIZE; k++) score_ff[k] <= SCORE_MIN;
                  end
                  REQ_SCORE: begin
                     if (!req_bad) score_ff[rq_ind_ff[PW-1:0]] <= rq_score_ff;
                  end
                  REQ_EVOLVE: begin
                     for (int k = 0; k < POP_SIZE; k++) order_ff[k] <= PW'(k);
                  end
                  default: ;
               endcase
            end
            ST_READ_WAIT: rgene_ff <= ram_rdata;
            ST_RAND_GENE: if (i_ff != (PW + 1)'(POP_SIZE) && g_ff < (CW + 1)'(n_eff))
               lfsr_ff <= lfsr_nx;
            ST_RAND_MUL: gene_ff <= m_res;
            ST_RAND_WR: begin
               if (g_ff == (CW + 1)'(MAX_GENES - 1)) begin
                  g_ff <= '0;
                  i_ff <= i_ff + 1'b1;
               end else g_ff <= g_ff + 1'b1;
            end
            ST_SORT_INIT: if (i_ff != (PW + 1)'(POP_SIZE)) begin
               cur_ff <= order_ff[i_p];
               j_ff <= i_ff;
            end else begin
               i_ff <= '0;
               best_ff <= score_ff[order_ff[0]];
            end
            ST_SORT_CMP: if (sort_move) begin
               order_ff[j_p] <= order_ff[jm1_p];
               j_ff <= j_ff - 1'b1;
            end
            ST_SORT_STEP: begin
               order_ff[j_p] <= cur_ff;
               i_ff <= i_ff + 1'b1;
            end
            ST_ELITE_RD: begin
               if (i_ff < (PW + 1)'(ELITES) && g_ff == (CW + 1)'(MAX_GENES)) begin
                  nscore_ff[i_p] <= score_ff[order_ff[i_p]];
                  g_ff <= '0;
                  i_ff <= i_ff + 1'b1;
               end
               second_ff <= 1'b0;
            end
            ST_ELITE_WR: g_ff <= g_ff + 1'b1;
            ST_TOUR_DRAW: if (i_ff != (PW + 1)'(POP_SIZE)) begin
               lfsr_ff <= lfsr_nx;
               ta_ff <= pick;
            end
            ST_TOUR_CMP: begin
               lfsr_ff <= lfsr_nx;
               // Ties go to the second pick.
               if (!second_ff)
                  p1_ff <= (score_ff[order_ff[ta_ff]] > score_ff[order_ff[pick]])
                           ? order_ff[ta_ff] : order_ff[pick];
               else
                  p2_ff <= (score_ff[order_ff[ta_ff]] > score_ff[order_ff[pick]])
                           ? order_ff[ta_ff] : order_ff[pick];
               second_ff <= !second_ff;
               xo_ff <= 1'b0;
               g_ff <= '0;
            end
            ST_XO_DRAW: begin
               nscore_ff[i_p] <= score_ff[p1_ff];
               if (n_eff > CW'(1)) lfsr_ff <= lfsr_nx;
            end
            ST_CUT_DRAW: begin
               lfsr_ff <= lfsr_nx;
               xo_ff <= 1'b1;
               cut_ff <= CW'(cut_prod[CW+15:16]) + CW'(1);
            end
            ST_MUT_DRAW: begin
               lfsr_ff <= lfsr_nx;
               gene_ff <= ram_rdata;
            end
            ST_MUT_VAL: lfsr_ff <= lfsr_nx;
            ST_MUT_MUL: gene_ff <= m_res;
            ST_GENE_WR: g_ff <= g_ff + 1'b1;
            ST_COPY_RD: if (g_ff == (CW + 1)'(MAX_GENES)) i_ff <= i_ff + 1'b1;
            ST_COPY_WR: g_ff <= g_ff + 1'b1;
            ST_DONE: begin
               buf_sel_ff <= !buf_sel_ff;
               for (int k = 0; k < POP_SIZE; k++) score_ff[k] <= nscore_ff[k];
               gen_ff <= gen_ff + 1'b1;
            end
            ST_RESP: if (!rsp_valid_ff || rsp_acc)
               rsp_data_ff <= {7'd0, best_ff, gen_ff, rgene_ff, status_ff};
            default: ;
         endcase
      end
   end

   `ASSERT_IMPLY(a_busy_not_ready, clock, reset, state_ff != ST_IDLE, !req_tready,
      "ready while busy")
   `ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid_ff && !rsp_tready, rsp_valid_ff,
      "response dropped")
   `ASSERT_IMPLY(a_cut_range, clock, reset, state_ff == ST_GENE_RD && xo_ff,
      cut_ff >= CW'(1) && cut_ff < n_eff, "crossover cut out of range")
endmodule

>>> sv/goe_mul.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// goe_mul
// Shared registered multiplier: 16-bit draw times a signed 33-bit span,
// result shifted right by 16 (arithmetic) and added to a base.
// ---------------------------------------------------------------------------
module goe_mul
   import goe_pkg::*;
(
   input  logic               clock,
   input  logic [15:0]        draw,
   input  logic signed [32:0] span,
   input  logic [31:0]        base,
   output logic [31:0]        result
);
   logic signed [49:0] prod_ff, prod_in;
   logic [31:0]        base_ff;
   logic signed [49:0] shifted;

   assign prod_in = $signed({1'b0, draw}) * span;
   always_ff @(posedge clock) begin
      prod_ff <= prod_in;
      base_ff <= base;
   end
   assign shifted = prod_ff >>> 16;
   assign result  = base_ff + shifted[31:0];
endmodule

>>> sv/goe_gene_ram.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// goe_gene_ram
// Single-port gene memory with registered read data.
// ---------------------------------------------------------------------------
module goe_gene_ram
   import goe_pkg::*;
#(
   parameter int DEPTH = POP_SIZE_DEF * MAX_GENES_DEF,
   parameter int WIDTH = GENE_BITS_DEF
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] addr,
   input  logic [WIDTH-1:0]         wr_data,
   output logic [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem [DEPTH];
   always_ff @(posedge clock) begin
      if (wr_en) mem[addr] <= wr_data;
      rd_data <= mem[addr];
   end
endmodule

>>> tb/sv/genetic_optimizer_engine_tb.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// genetic_optimizer_engine_tb
// Self-checking bench for the genetic optimizer engine. A scoreboard class
// mirrors the population, bounds, scores and LFSR. It predicts every
// response: bound writes, randomize, gene reads, score sets, evolve and bad
// requests. The stream sides idle at random, and the registers are
// reprogrammed between phases.
// ---------------------------------------------------------------------------
module genetic_optimizer_engine_tb;
   import goe_pkg::*;

   localparam int NPOP   = POP_SIZE_DEF;
   localparam int NGENES = MAX_GENES_DEF;
   localparam int NELITE = ELITE_COUNT_DEF;

   typedef struct {
      logic [2:0]         kind;
      logic [5:0]         ind;
      logic [3:0]         gi;
      logic signed [31:0] lo;
      logic signed [31:0] hi;
      logic signed [31:0] score;
   } request_type;

   typedef struct {
      logic               status;
      logic [31:0]        gene;
      logic [31:0]        gen;
      logic signed [31:0] best;
   } response_type;

   class optimizer_scoreboard;
      logic [31:0]        pop_genes[NPOP][NGENES];
      logic signed [31:0] pop_scores[NPOP];
      logic signed [31:0] lo_bound[NGENES];
      logic signed [31:0] hi_bound[NGENES];
      int                 rank[NPOP];
      logic [31:0]        lfsr;
      logic [31:0]        gen_count;
      logic [4:0]         gene_count;
      logic [31:0]        seed;
      logic [15:0]        xo_thresh;
      logic [15:0]        mut_thresh;
      response_type       pending[$];
      int                 errors;

      function new();
         for (int i = 0; i < NPOP; i++) begin
            pop_scores[i] = SCORE_MIN;
            rank[i] = i;
            for (int j = 0; j < NGENES; j++) pop_genes[i][j] = '0;
         end
         for (int j = 0; j < NGENES; j++) begin
            lo_bound[j] = '0;
            hi_bound[j] = '0;
         end
         lfsr = 32'd1;
         gen_count = '0;
         gene_count = 5'd4;
         seed = 32'd1;
         xo_thresh = 16'd45875;
         mut_thresh = 16'd6554;
         errors = 0;
      endfunction

      function void write_reg(csr_code_type idx, logic [31:0] value);
         case (idx)
            CSR_GENES: gene_count = value[4:0];
            CSR_SEED:  seed = value;
            CSR_XOVER: xo_thresh = value[15:0];
            CSR_MUT:   mut_thresh = value[15:0];
            default:   ;
         endcase
      endfunction

      function int genes_in_use();
         if (gene_count == 0) return 1;
         if (gene_count > NGENES) return NGENES;
         return gene_count;
      endfunction

      function logic [31:0] draw();
         lfsr = lfsr_next(lfsr);
         return {16'd0, lfsr[31:16]};
      endfunction

      function logic [31:0] scale(logic [31:0] r, int n);
         return (r * n) >> 16;
      endfunction

      function logic [31:0] uniform(logic signed [31:0] lo, logic signed [31:0] hi,
                                    logic [31:0] r);
         longint span;
         longint prod;
         span = longint'(hi) - longint'(lo);
         prod = longint'(r) * span;
         return 32'(longint'(lo) + (prod >>> 16));
      endfunction

      function int tournament();
         int a;
         int b;
         a = scale(draw(), NPOP);
         b = scale(draw(), NPOP);
         if (pop_scores[rank[a]] > pop_scores[rank[b]]) return a;
         return b;
      endfunction

      function logic signed [31:0] evolve();
         logic [31:0]        kids[NPOP][NGENES];
         logic signed [31:0] kid_scores[NPOP];
         int                 n;
         int                 cur;
         int                 j;
         int                 p1;
         int                 p2;
         int                 cut;
         n = genes_in_use();
         for (int i = 0; i < NPOP; i++) rank[i] = i;
         // Insertion sort keeps equal scores in their original order.
         for (int i = 1; i < NPOP; i++) begin
            cur = rank[i];
            j = i;
            while (j > 0 && pop_scores[rank[j-1]] < pop_scores[cur]) begin
               rank[j] = rank[j-1];
               j--;
            end
            rank[j] = cur;
         end
         for (int k = 0; k < NPOP; k++) begin
            if (k < NELITE) begin
               kids[k] = pop_genes[rank[k]];
               kid_scores[k] = pop_scores[rank[k]];
            end else begin
               p1 = rank[tournament()];
               p2 = rank[tournament()];
               kids[k] = pop_genes[p1];
               kid_scores[k] = pop_scores[p1];
               if (n > 1 && draw() < xo_thresh) begin
                  cut = 1 + scale(draw(), n - 1);
                  for (int g = cut; g < n; g++) kids[k][g] = pop_genes[p2][g];
               end
               for (int g = 0; g < n; g++)
                  if (draw() < mut_thresh)
                     kids[k][g] = uniform(lo_bound[g], hi_bound[g], draw());
            end
         end
         evolve = pop_scores[rank[0]];
         pop_genes = kids;
         pop_scores = kid_scores;
         gen_count++;
      endfunction

      function void randomize_population();
         int n;
         n = genes_in_use();
         lfsr = (seed != 0) ? seed : 32'd1;
         for (int i = 0; i < NPOP; i++) begin
            for (int g = 0; g < NGENES; g++)
               pop_genes[i][g] = (g < n) ? uniform(lo_bound[g], hi_bound[g], draw()) : '0;
            pop_scores[i] = SCORE_MIN;
         end
      endfunction

      function void note_request(request_type rq);
         response_type rs;
         rs.status = 1'b0;
         rs.gene = '0;
         rs.best = '0;
         case (rq.kind)
            REQ_BOUND: begin
               lo_bound[rq.gi] = rq.lo;
               hi_bound[rq.gi] = rq.hi;
            end
            REQ_RAND: randomize_population();
            REQ_READ: begin
               if (rq.ind < NPOP && rq.gi < genes_in_use()) rs.gene = pop_genes[rq.ind][rq.gi];
               else rs.status = 1'b1;
            end
            REQ_SCORE: begin
               if (rq.ind < NPOP) pop_scores[rq.ind] = rq.score;
               else rs.status = 1'b1;
            end
            REQ_EVOLVE: rs.best = evolve();
            default: rs.status = 1'b1;
         endcase
         rs.gen = gen_count;
         pending = {pending, rs};
      endfunction

      function void check_result(logic [103:0] data);
         response_type want;
         if (pending.size() == 0) begin
            $error("unexpected response transaction %h", data);
            errors++;
            return;
         end
         want = pending.pop_front();
         if (data[0] !== want.status) begin
            $error("status: expected %0d, actual %0d", want.status, data[0]);
            errors++;
         end
         if (data[32:1] !== want.gene) begin
            $error("gene_value: expected %h, actual %h", want.gene, data[32:1]);
            errors++;
         end
         if (data[64:33] !== want.gen) begin
            $error("generation: expected %0d, actual %0d", want.gen, data[64:33]);
            errors++;
         end
         if (data[96:65] !== want.best) begin
            $error("best_score: expected %0d, actual %0d", want.best, $signed(data[96:65]));
            errors++;
         end
      endfunction
   endclass

   logic         clock = 1'b0;
   logic         reset = 1'b1;
   logic         req_tvalid = 1'b0;
   logic         req_tready;
   logic [111:0] req_tdata = '0;
   logic         rsp_tvalid;
   logic         rsp_tready = 1'b0;
   logic [103:0] rsp_tdata;
   logic         csr_valid = 1'b0;
   logic         csr_ready;
   logic [1:0]   csr_index = '0;
   logic [31:0]  csr_data = '0;

   optimizer_scoreboard sb = new();
   bit                  no_idle = 1'b0;
   bit                  populated = 1'b0;

   genetic_optimizer_engine DUT (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready), .req_tdata(req_tdata),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready), .rsp_tdata(rsp_tdata),
      .csr_valid(csr_valid), .csr_ready(csr_ready), .csr_index(csr_index),
      .csr_data(csr_data)
   );

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   function bit idle_now();
      return !no_idle && ($urandom_range(99) < 31);
   endfunction

   always @(negedge clock) rsp_tready = reset ? 1'b0 : !idle_now();

   always @(posedge clock)
      if (!reset && rsp_tvalid && rsp_tready) sb.check_result(rsp_tdata);

   task automatic send_request(request_type rq);
      @(negedge clock);
      while (idle_now()) begin
         req_tvalid = 1'b0;
         @(negedge clock);
      end
      req_tdata = {3'b000, rq.score, rq.hi, rq.lo, rq.gi, rq.ind, rq.kind};
      req_tvalid = 1'b1;
      do @(posedge clock); while (!req_tready);
      sb.note_request(rq);
   endtask

   task automatic stop_requests();
      @(negedge clock);
      req_tvalid = 1'b0;
   endtask

   task automatic make_request(logic [2:0] kind, int ind, int gi,
                               logic [31:0] lo, logic [31:0] hi, logic [31:0] score);
      request_type rq;
      rq.kind = kind;
      rq.ind = 6'(ind);
      rq.gi = 4'(gi);
      rq.lo = lo;
      rq.hi = hi;
      rq.score = score;
      send_request(rq);
   endtask

   task automatic write_csr(csr_code_type idx, logic [31:0] value);
      @(negedge clock);
      csr_index = idx;
      csr_data = value;
      csr_valid = 1'b1;
      do @(posedge clock); while (!csr_ready);
      sb.write_reg(idx, value);
      @(negedge clock);
      csr_valid = 1'b0;
   endtask

   task automatic wait_drained();
      while (sb.pending.size() != 0) @(posedge clock);
      repeat (20) @(posedge clock);
   endtask

   function logic [31:0] rand_q16();
      case ($urandom_range(3))
         0: return $urandom();
         default: return 32'($signed($urandom_range(2000000)) - 1000000);
      endcase
   endfunction

   task automatic random_request();
      int          pick;
      logic [31:0] val;
      pick = $urandom_range(99);
      // Reads and evolves wait until the population has been randomized.
      if (!populated && pick >= 15 && pick < 20) pick = 15;
      if (!populated && pick >= 55 && pick < 93) pick = 96;
      if (pick < 15) begin
         make_request(REQ_BOUND, $urandom_range(63), $urandom_range(15),
                      rand_q16(), rand_q16(), $urandom());
      end else if (pick < 20) begin
         make_request(REQ_RAND, $urandom_range(63), $urandom_range(15),
                      $urandom(), $urandom(), $urandom());
         populated = 1'b1;
      end else if (pick < 55) begin
         val = ($urandom_range(3) == 0) ? $urandom() : $urandom_range(1000);
         make_request(REQ_SCORE, ($urandom_range(9) == 0) ? $urandom_range(63)
                      : $urandom_range(NPOP - 1), $urandom_range(15),
                      $urandom(), $urandom(), val);
      end else if (pick < 85) begin
         make_request(REQ_READ, ($urandom_range(9) == 0) ? $urandom_range(63)
                      : $urandom_range(NPOP - 1), $urandom_range(15),
                      $urandom(), $urandom(), $urandom());
      end else if (pick < 93) begin
         make_request(REQ_EVOLVE, $urandom_range(63), $urandom_range(15),
                      $urandom(), $urandom(), $urandom());
      end else begin
         make_request(3'($urandom_range(7, 5)), $urandom_range(63), $urandom_range(15),
                      $urandom(), $urandom(), $urandom());
      end
   endtask

   initial begin
      logic [31:0] genes_set[6];
      logic [31:0] seed_set[6];
      logic [31:0] xo_set[6];
      logic [31:0] mut_set[6];
      genes_set = '{32'd4, 32'd1, 32'd16, 32'd0, {27'($urandom()), 5'd31},
                    $urandom_range(16, 1)};
      seed_set = '{32'd1, 32'd0, 32'hFFFF_FFFF, $urandom(), $urandom(), $urandom()};
      xo_set = '{32'd45875, 32'd65535, 32'd0, $urandom(), $urandom_range(65535), 32'd30000};
      mut_set = '{32'd6554, 32'd65535, 32'd0, $urandom(), $urandom_range(65535), 32'd20000};
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // Directed: bound extremes, inverted bounds, range checks and bad kinds.
      make_request(REQ_BOUND, 0, 0, 32'h8000_0000, 32'h7FFF_FFFF, 0);
      make_request(REQ_BOUND, 0, 1, 32'sd100000, -32'sd100000, 0);
      make_request(REQ_BOUND, 63, 15, 32'd0, 32'h7FFF_FFFF, 32'hFFFF_FFFF);
      make_request(REQ_BOUND, 0, 3, -32'sd65536, 32'sd65536, 0);
      make_request(REQ_RAND, 0, 0, 0, 0, 0);
      populated = 1'b1;
      make_request(REQ_READ, 0, 0, 0, 0, 0);
      make_request(REQ_READ, 19, 3, 0, 0, 0);
      make_request(REQ_READ, 20, 0, 0, 0, 0);
      make_request(REQ_READ, 0, 15, 0, 0, 0);
      make_request(REQ_SCORE, 0, 0, 0, 0, 32'h7FFF_FFFF);
      make_request(REQ_SCORE, 19, 0, 0, 0, 32'h8000_0000);
      make_request(REQ_SCORE, 5, 0, 0, 0, 32'h7FFF_FFFF);
      make_request(REQ_SCORE, 63, 0, 0, 0, 32'd7);
      make_request(REQ_EVOLVE, 0, 0, 0, 0, 0);
      make_request(3'd5, 0, 0, 0, 0, 0);
      make_request(3'd7, 63, 15, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
      make_request(REQ_EVOLVE, 0, 0, 0, 0, 0);
      make_request(REQ_READ, 1, 1, 0, 0, 0);
      stop_requests();

      for (int p = 0; p < 6; p++) begin
         wait_drained();
         write_csr(CSR_GENES, genes_set[p]);
         write_csr(CSR_SEED, seed_set[p]);
         write_csr(CSR_XOVER, xo_set[p]);
         write_csr(CSR_MUT, mut_set[p]);
         no_idle = (p == 2);
         for (int n = 0; n < 125; n++) random_request();
         stop_requests();
      end
      no_idle = 1'b0;

      while (sb.pending.size() != 0) @(posedge clock);
      repeat (50) @(posedge clock);
      if (sb.errors == 0 && sb.pending.size() == 0) begin
         $display("tb: success");
      end else begin
         $display("tb: failure");
      end
      $finish;
   end

   initial begin
      #200_000_000;
      $display("tb: failure");
      $finish;
   end
endmodule
